// File: hdl/iidl_pkg.sv
`default_nettype none

package iidl_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LEN_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    OP_FILL   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_GET    = 3'd3,
    OP_SET    = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_GET_RD,
    ST_SET_WR,
    ST_DONE,
    ST_DONE_GET
  } state_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PREV,
    RD_NEXT,
    RD_POS
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_FILL,
    WR_SHIFT,
    WR_VAL
  } wr_sel_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_CNT,
    PTR_POS,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_FILL,
    CNT_INC,
    CNT_DEC
  } cnt_sel_e;

  typedef struct packed {
    logic     accept;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    ptr_sel_e ptr_sel;
    cnt_sel_e cnt_sel;
    logic     out_load;
    logic     out_get;
  } cmd_t;

  typedef struct packed {
    logic in_err;
    logic out_free;
    logic fill_end;
    logic up_end;
    logic dn_end;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/indexed_insert_delete_list.sv
// Steps: a rejected request goes straight to the result; get reads the entry, then loads
// it; set writes the value; fill writes each entry from 0 up; insert and delete move each
// entry past position by one slot, a read state then a write state per entry. One item
// at a time: in_stall_o holds until the result loads; the entry store's read is registered.
// Reset: length clears to zero and the result register empties; entry store
// contents are undefined and not cleared, so no clearing pass is needed.
`default_nettype none

module indexed_insert_delete_list
  import iidl_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic        [MODE_W-1:0] mode_i,
  input  wire logic        [POS_W-1:0]  position_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  input  wire logic        [POS_W-1:0]  fill_count_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed      [VAL_W-1:0]  read_value_o,
  output logic             [LEN_W-1:0]  current_length_o,
  output logic                          error_o
);

  cmd_t    cmd;
  status_t status;

  iidl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  iidl_dpath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .fill_count_i     (fill_count_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .read_value_o     (read_value_o),
    .current_length_o (current_length_o),
    .error_o          (error_o)
  );

endmodule

`default_nettype wire

// File: hdl/iidl_ctrl.sv
`default_nettype none

module iidl_ctrl
  import iidl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [MODE_W-1:0] mode_i,
  output logic                   in_stall_o,
  input  wire status_t           status_i,
  output cmd_t                   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{accept: 1'b0, rd_sel: RD_NONE, wr_sel: WR_NONE, ptr_sel: PTR_HOLD,
                cnt_sel: CNT_HOLD, out_load: 1'b0, out_get: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.in_err) begin
            state_d = ST_DONE;
          end else begin
            unique case (op_e'(mode_i))
              OP_FILL: begin
                cmd_o.ptr_sel = PTR_ZERO;
                state_d       = ST_FILL;
              end
              OP_INSERT: begin
                cmd_o.ptr_sel = PTR_CNT;
                state_d       = ST_UP_RD;
              end
              OP_DELETE: begin
                cmd_o.ptr_sel = PTR_POS;
                state_d       = ST_DN_RD;
              end
              OP_GET:  state_d = ST_GET_RD;
              OP_SET:  state_d = ST_SET_WR;
              default: state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_FILL: begin
        if (status_i.fill_end) begin
          cmd_o.cnt_sel = CNT_FILL;
          state_d       = ST_DONE;
        end else begin
          cmd_o.wr_sel  = WR_FILL;
          cmd_o.ptr_sel = PTR_INC;
        end
      end
      ST_UP_RD: begin
        if (status_i.up_end) begin
          cmd_o.wr_sel  = WR_VAL;
          cmd_o.cnt_sel = CNT_INC;
          state_d       = ST_DONE;
        end else begin
          cmd_o.rd_sel = RD_PREV;
          state_d      = ST_UP_WR;
        end
      end
      ST_UP_WR: begin
        cmd_o.wr_sel  = WR_SHIFT;
        cmd_o.ptr_sel = PTR_DEC;
        state_d       = ST_UP_RD;
      end
      ST_DN_RD: begin
        if (status_i.dn_end) begin
          cmd_o.cnt_sel = CNT_DEC;
          state_d       = ST_DONE;
        end else begin
          cmd_o.rd_sel = RD_NEXT;
          state_d      = ST_DN_WR;
        end
      end
      ST_DN_WR: begin
        cmd_o.wr_sel  = WR_SHIFT;
        cmd_o.ptr_sel = PTR_INC;
        state_d       = ST_DN_RD;
      end
      ST_GET_RD: begin
        cmd_o.rd_sel = RD_POS;
        state_d      = ST_DONE_GET;
      end
      ST_SET_WR: begin
        cmd_o.wr_sel = WR_VAL;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DONE_GET: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_get  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/iidl_dpath.sv
`default_nettype none

module iidl_dpath
  import iidl_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic        [MODE_W-1:0] mode_i,
  input  wire logic        [POS_W-1:0]  position_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  input  wire logic        [POS_W-1:0]  fill_count_i,
  input  wire cmd_t                     cmd_i,
  output status_t                       status_o,
  input  wire logic                     out_stall_i,
  output logic                          out_valid_o,
  output logic signed      [VAL_W-1:0]  read_value_o,
  output logic             [LEN_W-1:0]  current_length_o,
  output logic                          error_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [WORD_BITS-1:0] mem_q [CAPACITY];
  logic [WORD_BITS-1:0] rdata_q;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]     pos_q;
  logic [CNT_W-1:0]     fill_q;
  logic [WORD_BITS-1:0] val_q;
  logic                 err_q;

  logic                 out_valid_q;
  logic signed [VAL_W-1:0] rv_q;
  logic [LEN_W-1:0]     len_q;
  logic                 oerr_q;

  logic [CMP_W-1:0] pos_x, fill_x, cnt_x, cap_x;
  logic             in_err;
  logic [CNT_W:0]   ptr_inc;
  logic [CNT_W:0]   cnt_ext;

  // request checks against the current length and the capacity
  assign pos_x  = CMP_W'(position_i);
  assign fill_x = CMP_W'(fill_count_i);
  assign cnt_x  = CMP_W'(count_q);
  assign cap_x  = CMP_W'(CAPACITY);

  always_comb begin
    unique case (op_e'(mode_i))
      OP_FILL:   in_err = (fill_x > cap_x);
      OP_INSERT: in_err = (pos_x > cnt_x) || (cnt_x >= cap_x);
      OP_DELETE,
      OP_GET,
      OP_SET:    in_err = (pos_x >= cnt_x);
      default:   in_err = 1'b1;
    endcase
  end

  assign ptr_inc = {1'b0, ptr_q} + 1'b1;
  assign cnt_ext = {1'b0, count_q};

  assign status_o.in_err   = in_err;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.fill_end = (ptr_q == fill_q);
  assign status_o.up_end   = (ptr_q == pos_q);
  assign status_o.dn_end   = (ptr_inc >= cnt_ext);

  // cursor and length
  always_comb begin
    case (cmd_i.ptr_sel)
      PTR_CNT:  ptr_d = count_q;
      PTR_POS:  ptr_d = CNT_W'(position_i);
      PTR_ZERO: ptr_d = '0;
      PTR_INC:  ptr_d = ptr_q + 1'b1;
      PTR_DEC:  ptr_d = ptr_q - 1'b1;
      default:  ptr_d = ptr_q;
    endcase
    case (cmd_i.cnt_sel)
      CNT_FILL: count_d = fill_q;
      CNT_INC:  count_d = count_q + 1'b1;
      CNT_DEC:  count_d = count_q - 1'b1;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      if (cmd_i.accept) begin
        err_q <= in_err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q  <= CNT_W'(position_i);
      fill_q <= CNT_W'(fill_count_i);
      val_q  <= WORD_BITS'($unsigned(value_i));
    end
  end

  // entry store: one write and one registered read per cycle
  logic [AW-1:0]        raddr, waddr;
  logic                 re, we;
  logic [WORD_BITS-1:0] wdata;
  logic [CNT_W-1:0]     ptr_prev;

  assign ptr_prev = ptr_q - 1'b1;

  always_comb begin
    re = 1'b1;
    case (cmd_i.rd_sel)
      RD_PREV: raddr = ptr_prev[AW-1:0];
      RD_NEXT: raddr = ptr_inc[AW-1:0];
      RD_POS:  raddr = pos_q[AW-1:0];
      default: begin
        raddr = ptr_q[AW-1:0];
        re    = 1'b0;
      end
    endcase
    we    = 1'b1;
    waddr = ptr_q[AW-1:0];
    case (cmd_i.wr_sel)
      WR_FILL:  wdata = WORD_BITS'(ptr_inc);
      WR_SHIFT: wdata = rdata_q;
      WR_VAL: begin
        wdata = val_q;
        waddr = pos_q[AW-1:0];
      end
      default: begin
        wdata = rdata_q;
        we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rv_q   <= cmd_i.out_get ? VAL_W'(rdata_q) : '0;
      len_q  <= LEN_W'(count_q);
      oerr_q <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = rv_q;
  assign current_length_o = len_q;
  assign error_o          = oerr_q;

endmodule

`default_nettype wire
